FILE: design/necir_pkg.sv
`default_nettype none

package necir_pkg;

	// frame length and derived widths
	localparam int FRAME_BITS = 32;
	localparam int CNT_W      = $clog2(FRAME_BITS + 1);

	// configuration port
	localparam int REG_W     = 16;
	localparam int N_REGS    = 8;
	localparam int CFG_IDX_W = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK_MIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK_MAX  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK_MAX     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_SPACE_MAX    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESHOLD    = 3'd7;

	// register reset values in microseconds
	localparam logic [REG_W-1:0] REG_RESET [N_REGS] = '{
		16'd8500, 16'd9500, 16'd4000, 16'd5000,
		16'd400,  16'd700,  16'd1800, 16'd1000
	};

	// stream widths
	localparam int IN_DATA_W  = 16;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 48;
	localparam int OUT_USER_W = 1;

	// output tdata layout
	localparam int OFS_FRAME   = 0;
	localparam int OFS_CMD     = 32;
	localparam int OFS_RISING  = 40;
	localparam int OFS_ENABLED = 41;
	localparam int OFS_PHASE   = 42;
	localparam int OUT_FIELD_W = 45;

	// item operations
	typedef enum logic [IN_USER_W-1:0] {
		OP_EDGE    = 2'd0,
		OP_TIMEOUT = 2'd1,
		OP_REARM   = 2'd2
	} op_t;

	// decode phases as reported on the output
	localparam logic [2:0] PCODE_IDLE         = 3'd0;
	localparam logic [2:0] PCODE_LEADER_MARK  = 3'd1;
	localparam logic [2:0] PCODE_LEADER_SPACE = 3'd2;
	localparam logic [2:0] PCODE_BIT_MARK     = 3'd3;
	localparam logic [2:0] PCODE_BIT_SPACE    = 3'd4;

endpackage

`default_nettype wire

FILE: design/nec_ir_pulse_decoder.sv
// A result item is registered twice: the input register takes the input item, then
// the result register takes the result once it can accept one.
// Throughput: one item per cycle; the state update is a single pass of window
// compares and a one-bit shift. Output stalls back-pressure through tready.
// Reset (arst_n low, asynchronous): idle, edges enabled, code and command zero,
// expected edge falling, configuration registers back to their default windows.
`default_nettype none

module nec_ir_pulse_decoder (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// configuration write port
	input  wire                                 cfg_we,
	input  wire [necir_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [necir_pkg::REG_W-1:0]          cfg_data,
	// input items
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire [necir_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [15:0] interval_us
	input  wire [necir_pkg::IN_USER_W-1:0]      s_axis_tuser,  // [1:0] operation
	// result items
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// [31:0] frame_code, [39:32] command_byte, [40] next_edge_rising,
	// [41] edges_enabled, [44:42] decode_phase, [47:45] zero
	output logic [necir_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	output logic [necir_pkg::OUT_USER_W-1:0]    m_axis_tuser   // [0] code_valid
);
	import necir_pkg::*;

	// one-hot decode phase
	typedef enum logic [4:0] {
		PH_IDLE         = 5'b00001,
		PH_LEADER_MARK  = 5'b00010,
		PH_LEADER_SPACE = 5'b00100,
		PH_BIT_MARK     = 5'b01000,
		PH_BIT_SPACE    = 5'b10000
	} phase_t;

	logic [REG_W-1:0]      cfg_q [N_REGS];

	logic                  valid_s1;
	logic [IN_USER_W-1:0]  op_s1;
	logic [IN_DATA_W-1:0]  ival_s1;
	logic                  out_free;
	logic                  step;

	phase_t                phase_q, phase_d;
	logic [CNT_W-1:0]      bits_q, bits_d, bits_inc;
	logic [FRAME_BITS-1:0] shift_q, shift_d;
	logic                  rising_q, rising_d;
	logic                  enable_q, enable_d;
	logic [7:0]            cmd_q, cmd_d;
	logic                  done_d;
	logic [63:0]           shift_next_ext, shift_cur_ext;

	logic                  out_valid_q;
	logic                  code_valid_q;
	logic [31:0]           frame_q;
	logic [7:0]            cmd_out_q;
	logic                  rising_out_q;
	logic                  enable_out_q;
	logic [2:0]            phase_out_q;
	logic [2:0]            phase_code_d;

	function automatic logic in_win(input logic [15:0] t, input logic [15:0] lo,
		input logic [15:0] hi);
		return (t > lo) && (t < hi);
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_REGS; i++) cfg_q[i] <= REG_RESET[i];
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// handshake: the input register moves when the result register can take an item
	assign out_free      = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= s_axis_tuser;
			ival_s1 <= s_axis_tdata;
		end
	end

	// next state for one item
	assign bits_inc = bits_q + CNT_W'(1);

	always_comb begin
		phase_d  = phase_q;
		bits_d   = bits_q;
		shift_d  = shift_q;
		rising_d = rising_q;
		enable_d = enable_q;
		cmd_d    = cmd_q;
		done_d   = 1'b0;
		shift_next_ext = 64'(shift_q);
		case (op_s1)
			OP_EDGE: begin
				if (enable_q) begin
					case (phase_q)
						PH_IDLE: begin
							bits_d   = '0;
							shift_d  = '0;
							phase_d  = PH_LEADER_MARK;
							rising_d = 1'b1;
						end
						PH_LEADER_MARK: begin
							phase_d  = in_win(ival_s1, cfg_q[REG_LEADER_MARK_MIN],
								cfg_q[REG_LEADER_MARK_MAX]) ? PH_LEADER_SPACE : PH_IDLE;
							rising_d = 1'b0;
						end
						PH_LEADER_SPACE: begin
							phase_d  = in_win(ival_s1, cfg_q[REG_LEADER_SPACE_MIN],
								cfg_q[REG_LEADER_SPACE_MAX]) ? PH_BIT_MARK : PH_IDLE;
							rising_d = 1'b1;
						end
						PH_BIT_MARK: begin
							phase_d  = in_win(ival_s1, cfg_q[REG_PULSE_MIN],
								cfg_q[REG_BIT_MARK_MAX]) ? PH_BIT_SPACE : PH_IDLE;
							rising_d = 1'b0;
						end
						PH_BIT_SPACE: begin
							rising_d = 1'b1;
							if (in_win(ival_s1, cfg_q[REG_PULSE_MIN], cfg_q[REG_BIT_SPACE_MAX]))
							begin
								// msb first, long space is a one
								shift_d = {shift_q[FRAME_BITS-2:0],
									(ival_s1 > cfg_q[REG_ONE_THRESHOLD])};
								shift_next_ext = 64'(shift_d);
								bits_d  = bits_inc;
								if (bits_inc >= CNT_W'(FRAME_BITS)) begin
									done_d   = 1'b1;
									enable_d = 1'b0;
									cmd_d    = shift_next_ext[15:8];
									phase_d  = PH_IDLE;
								end else begin
									phase_d  = PH_BIT_MARK;
								end
							end else begin
								phase_d = PH_IDLE;
							end
						end
						default: begin
							phase_d = phase_q;
						end
					endcase
				end
			end
			OP_TIMEOUT: begin
				phase_d  = PH_IDLE;
				rising_d = 1'b0;
			end
			OP_REARM: begin
				enable_d = 1'b1;
				rising_d = 1'b0;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	// phase as reported
	always_comb begin
		case (phase_d)
			PH_IDLE:         phase_code_d = PCODE_IDLE;
			PH_LEADER_MARK:  phase_code_d = PCODE_LEADER_MARK;
			PH_LEADER_SPACE: phase_code_d = PCODE_LEADER_SPACE;
			PH_BIT_MARK:     phase_code_d = PCODE_BIT_MARK;
			PH_BIT_SPACE:    phase_code_d = PCODE_BIT_SPACE;
			default:         phase_code_d = PCODE_IDLE;
		endcase
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			bits_q   <= '0;
			shift_q  <= '0;
			rising_q <= 1'b0;
			enable_q <= 1'b1;
			cmd_q    <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			bits_q   <= bits_d;
			shift_q  <= shift_d;
			rising_q <= rising_d;
			enable_q <= enable_d;
			cmd_q    <= cmd_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign shift_cur_ext = 64'(shift_d);

	always_ff @(posedge clk) begin
		if (step) begin
			code_valid_q <= done_d;
			frame_q      <= shift_cur_ext[31:0];
			cmd_out_q    <= cmd_d;
			rising_out_q <= rising_d;
			enable_out_q <= enable_d;
			phase_out_q  <= phase_code_d;
		end
	end

	// output packing
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = code_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W - OUT_FIELD_W)'(0), phase_out_q, enable_out_q,
		rising_out_q, cmd_out_q, frame_q};

endmodule

`default_nettype wire

FILE: design/necir_chk.sv
`default_nettype none

module necir_chk (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 m_axis_tvalid,
	input  wire                                 m_axis_tready,
	input  wire [necir_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  wire [necir_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
	import necir_pkg::*;

	logic [2:0] phase_w;
	logic       rising_w;
	logic       enabled_w;

	assign phase_w   = m_axis_tdata[OFS_PHASE +: 3];
	assign rising_w  = m_axis_tdata[OFS_RISING];
	assign enabled_w = m_axis_tdata[OFS_ENABLED];

	// a completed frame leaves the decoder idle, disabled, waiting for a rising edge
	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |->
		(!enabled_w && rising_w && phase_w == PCODE_IDLE))
		else $error("completed frame with wrong decoder state");

	// edges stay off only while the decoder sits idle
	a_disabled_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !enabled_w) |-> (phase_w == PCODE_IDLE))
		else $error("disabled decoder outside idle");

	// in a space phase the next edge is always a falling one
	a_polarity_space: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (phase_w == PCODE_LEADER_SPACE || phase_w == PCODE_BIT_SPACE))
		|-> !rising_w)
		else $error("space phase must expect a falling edge");

	// stalled result item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("result item changed while stalled");

endmodule

bind nec_ir_pulse_decoder necir_chk u_necir_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
